@@ rtl/sbmq_pkg.sv @@
// Shared types and codes for the shared-buffer multi-queue core.
package sbmq_pkg;

    localparam int IN_DATA_W  = 32;
    localparam int QID_W      = 2;
    localparam int STATUS_W   = 2;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_OVERFLOW  = 2'd1;
    localparam status_t ST_UNDERFLOW = 2'd2;

    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    // entry store operation: read link/data, write link, write data
    typedef struct packed {
        logic rd;
        logic wr_link;
        logic wr_data;
    } link_op_t;

    // queue table operation: read head/tail, write head, write tail
    typedef struct packed {
        logic rd;
        logic wr_head;
        logic wr_tail;
    } qtab_op_t;

endpackage

@@ rtl/shared_buffer_multi_queue_core.sv @@
// Top level: request sequencer for multiple queues sharing one entry store.
//
//  channel   ports                              handshake
//  request   req_type, queue_id, data_in        taken when start && !busy
//  result    status, data_out                   valid for one cycle on done
//
//  One request gives one result. done rises the cycle after the last step.
//  The steps follow the chain of registered reads: queue head, then the
//  entry's next pointer. An enqueue behind an existing tail takes one more
//  step; overflow or underflow end after the head read, an unknown queue in idle.
//  busy is high while a request is in progress; the receiver cannot stall.
//  Reset empties all queues and rebuilds the free list with no clearing pass.
module shared_buffer_multi_queue_core #(
    parameter int NUM_QUEUES  = 4,
    parameter int NUM_ENTRIES = 16,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 req_type,
    input  logic [sbmq_pkg::QID_W-1:0]           queue_id,
    input  logic signed [sbmq_pkg::IN_DATA_W-1:0] data_in,
    output logic                                 done,
    output sbmq_pkg::status_t                    status,
    output logic signed [sbmq_pkg::IN_DATA_W-1:0] data_out
);
    import sbmq_pkg::*;

    localparam int PTR_W = $clog2(NUM_ENTRIES + 1);
    localparam int IDX_W = $clog2(NUM_ENTRIES);
    localparam int QI_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam logic [PTR_W-1:0] PTR_NULL = PTR_W'(NUM_ENTRIES);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_LOOK     = 3'd1;
    localparam logic [2:0] S_ENQ_LINK = 3'd2;
    localparam logic [2:0] S_ENQ_TAIL = 3'd3;
    localparam logic [2:0] S_DEQ      = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic                  req_reg, req_next;
    logic [QI_W-1:0]       q_reg, q_next;
    logic [DATA_WIDTH-1:0] data_reg, data_next;
    logic [IDX_W-1:0]      slot_reg, slot_next;
    logic [PTR_W-1:0]      free_head_reg, free_head_next;
    logic                  done_reg, done_next;
    status_t               status_reg, status_next;
    logic [IN_DATA_W-1:0]  data_out_reg, data_out_next;

    qtab_op_t              qt_op;
    logic [QI_W-1:0]       qt_q;
    logic [PTR_W-1:0]      qt_wr_head;
    logic [PTR_W-1:0]      qt_head;
    logic [IDX_W-1:0]      qt_tail;

    link_op_t              es_op;
    logic [IDX_W-1:0]      es_rd_addr;
    logic [IDX_W-1:0]      es_wr_addr;
    logic [PTR_W-1:0]      es_wr_link;
    logic [PTR_W-1:0]      es_link;
    logic [DATA_WIDTH-1:0] es_data;

    logic                  q_known;

    assign q_known = ({{(32 - QID_W){1'b0}}, queue_id} < 32'(NUM_QUEUES));
    assign qt_q    = (state_reg == S_IDLE) ? QI_W'(queue_id) : q_reg;

    sbmq_queue_table #(
        .NUM_QUEUES  (NUM_QUEUES),
        .NUM_ENTRIES (NUM_ENTRIES),
        .PTR_W       (PTR_W),
        .IDX_W       (IDX_W),
        .QI_W        (QI_W)
    ) u_qtab (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (qt_op),
        .q           (qt_q),
        .wr_head_ptr (qt_wr_head),
        .wr_tail_idx (slot_reg),
        .head_ptr    (qt_head),
        .tail_idx    (qt_tail)
    );

    sbmq_entry_store #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .DATA_WIDTH  (DATA_WIDTH),
        .PTR_W       (PTR_W),
        .IDX_W       (IDX_W)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (es_op),
        .rd_addr     (es_rd_addr),
        .wr_addr     (es_wr_addr),
        .wr_link     (es_wr_link),
        .wr_data     (data_reg),
        .rd_link     (es_link),
        .rd_data     (es_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        q_next         = q_reg;
        data_next      = data_reg;
        slot_next      = slot_reg;
        free_head_next = free_head_reg;
        done_next      = 1'b0;
        status_next    = ST_OK;
        data_out_next  = '0;
        qt_op          = '0;
        qt_wr_head     = slot_reg;
        es_op          = '0;
        es_rd_addr     = slot_reg;
        es_wr_addr     = slot_reg;
        es_wr_link     = PTR_NULL;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (!q_known)
                    begin
                        done_next   = 1'b1;
                        status_next = (req_type == REQ_DEQ) ? ST_UNDERFLOW : ST_OVERFLOW;
                    end
                    else
                    begin
                        qt_op.rd   = 1'b1;
                        req_next   = req_type;
                        q_next     = QI_W'(queue_id);
                        data_next  = DATA_WIDTH'($unsigned(data_in));
                        state_next = S_LOOK;
                    end
                end
            end

            S_LOOK:
            begin
                if (req_reg == REQ_ENQ)
                begin
                    if (free_head_reg >= PTR_NULL)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_OVERFLOW;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        es_op.rd   = 1'b1;
                        es_rd_addr = IDX_W'(free_head_reg);
                        slot_next  = IDX_W'(free_head_reg);
                        state_next = S_ENQ_LINK;
                    end
                end
                else
                begin
                    if (qt_head >= PTR_NULL)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_UNDERFLOW;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        es_op.rd   = 1'b1;
                        es_rd_addr = IDX_W'(qt_head);
                        slot_next  = IDX_W'(qt_head);
                        state_next = S_DEQ;
                    end
                end
            end

            S_ENQ_LINK:
            begin
                // new entry ends the queue; free list advances past it
                free_head_next = es_link;
                es_op.wr_link  = 1'b1;
                es_op.wr_data  = 1'b1;
                es_wr_link     = PTR_NULL;
                qt_op.wr_tail  = 1'b1;
                if (qt_head >= PTR_NULL)
                begin
                    qt_op.wr_head = 1'b1;
                    qt_wr_head    = PTR_W'(slot_reg);
                    done_next     = 1'b1;
                    status_next   = ST_OK;
                    state_next    = S_IDLE;
                end
                else
                begin
                    state_next = S_ENQ_TAIL;
                end
            end

            S_ENQ_TAIL:
            begin
                es_op.wr_link = 1'b1;
                es_wr_addr    = qt_tail;
                es_wr_link    = PTR_W'(slot_reg);
                done_next     = 1'b1;
                status_next   = ST_OK;
                state_next    = S_IDLE;
            end

            S_DEQ:
            begin
                // unlink head, push the entry on the front of the free list
                qt_op.wr_head  = 1'b1;
                qt_wr_head     = es_link;
                es_op.wr_link  = 1'b1;
                es_wr_link     = free_head_reg;
                free_head_next = PTR_W'(slot_reg);
                done_next      = 1'b1;
                status_next    = ST_OK;
                data_out_next  = IN_DATA_W'(es_data);
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        q_reg        <= q_next;
        data_reg     <= data_next;
        slot_reg     <= slot_next;
        status_reg   <= status_next;
        data_out_reg <= data_out_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign status   = status_reg;
    assign data_out = $signed(data_out_reg);

endmodule

@@ rtl/sbmq_queue_table.sv @@
// Per-queue head and tail pointer store with head valid bits.
module sbmq_queue_table #(
    parameter int NUM_QUEUES  = 4,
    parameter int NUM_ENTRIES = 16,
    parameter int PTR_W       = 5,
    parameter int IDX_W       = 4,
    parameter int QI_W        = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sbmq_pkg::qtab_op_t  op,
    input  logic [QI_W-1:0]     q,
    input  logic [PTR_W-1:0]    wr_head_ptr,
    input  logic [IDX_W-1:0]    wr_tail_idx,
    output logic [PTR_W-1:0]    head_ptr,
    output logic [IDX_W-1:0]    tail_idx
);
    import sbmq_pkg::*;

    localparam logic [PTR_W-1:0] PTR_NULL = PTR_W'(NUM_ENTRIES);

    logic [PTR_W-1:0]      head_mem [NUM_QUEUES];
    logic [IDX_W-1:0]      tail_mem [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] head_vld_reg;
    logic [PTR_W-1:0]      head_rd_reg;
    logic [IDX_W-1:0]      tail_rd_reg;
    logic                  vld_rd_reg;

    always_ff @(posedge clk)
    begin
        if (op.wr_head)
        begin
            head_mem[q] <= wr_head_ptr;
        end
        if (op.wr_tail)
        begin
            tail_mem[q] <= wr_tail_idx;
        end
        if (op.rd)
        begin
            head_rd_reg <= head_mem[q];
            tail_rd_reg <= tail_mem[q];
        end
    end

    // a queue never written since reset is empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_vld_reg <= '0;
            vld_rd_reg   <= 1'b0;
        end
        else
        begin
            if (op.wr_head)
            begin
                head_vld_reg[q] <= 1'b1;
            end
            if (op.rd)
            begin
                vld_rd_reg <= head_vld_reg[q];
            end
        end
    end

    assign head_ptr = vld_rd_reg ? head_rd_reg : PTR_NULL;
    assign tail_idx = tail_rd_reg;

endmodule

@@ rtl/sbmq_entry_store.sv @@
// Entry data and next-pointer store with fill count for the initial free chain.
module sbmq_entry_store #(
    parameter int NUM_ENTRIES = 16,
    parameter int DATA_WIDTH  = 32,
    parameter int PTR_W       = 5,
    parameter int IDX_W       = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sbmq_pkg::link_op_t  op,
    input  logic [IDX_W-1:0]    rd_addr,
    input  logic [IDX_W-1:0]    wr_addr,
    input  logic [PTR_W-1:0]    wr_link,
    input  logic [DATA_WIDTH-1:0] wr_data,
    output logic [PTR_W-1:0]    rd_link,
    output logic [DATA_WIDTH-1:0] rd_data
);
    import sbmq_pkg::*;

    logic [PTR_W-1:0]      link_mem [NUM_ENTRIES];
    logic [DATA_WIDTH-1:0] data_mem [NUM_ENTRIES];
    logic [PTR_W-1:0]      link_rd_reg;
    logic [DATA_WIDTH-1:0] data_rd_reg;
    logic [IDX_W-1:0]      addr_rd_reg;
    logic                  fresh_rd_reg;
    logic [PTR_W-1:0]      fill_reg;
    logic [PTR_W-1:0]      fill_next;

    always_ff @(posedge clk)
    begin
        if (op.wr_link)
        begin
            link_mem[wr_addr] <= wr_link;
        end
        if (op.wr_data)
        begin
            data_mem[wr_addr] <= wr_data;
        end
        if (op.rd)
        begin
            link_rd_reg <= link_mem[rd_addr];
            data_rd_reg <= data_mem[rd_addr];
            addr_rd_reg <= rd_addr;
        end
    end

    // entries at or above the fill count were never taken: they still
    // chain to the next index, the last one to null
    always_comb
    begin
        fill_next = fill_reg;
        if (op.wr_data && (PTR_W'(wr_addr) == fill_reg))
        begin
            fill_next = fill_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            fresh_rd_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (op.rd)
            begin
                fresh_rd_reg <= (PTR_W'(rd_addr) >= fill_reg);
            end
        end
    end

    assign rd_link = fresh_rd_reg ? (PTR_W'(addr_rd_reg) + PTR_W'(1)) : link_rd_reg;
    assign rd_data = data_rd_reg;

endmodule

@@ test/tb_shared_buffer_multi_queue_core.sv @@
// Testbench for shared_buffer_multi_queue_core: directed and random queue traffic.
`timescale 1ns / 100ps

module tb_shared_buffer_multi_queue_core;

    import sbmq_pkg::*;

    localparam int NUM_QUEUES  = 4;
    localparam int NUM_ENTRIES = 16;
    localparam int DATA_WIDTH  = 32;

    localparam logic [4:0] PTR_NONE = 5'(NUM_ENTRIES);
    localparam int STALL_LIMIT   = 2000;
    localparam int TAIL_CYCLES   = 10;
    localparam int MAX_REPORTS   = 10;

    typedef struct {
        status_t            st;
        logic signed [31:0] data;
    } reply_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     req_type = REQ_ENQ;
    logic [QID_W-1:0]         queue_id = '0;
    logic signed [IN_DATA_W-1:0] data_in = '0;
    logic                     busy;
    logic                     done;
    status_t                  status;
    logic signed [IN_DATA_W-1:0] data_out;

    // predictor state
    logic signed [31:0] entry_val [NUM_ENTRIES];
    logic [4:0]         next_ptr  [NUM_ENTRIES];
    logic [4:0]         head_ptr  [NUM_QUEUES];
    logic [3:0]         tail_ptr  [NUM_QUEUES];
    logic [4:0]         free_ptr;

    reply_t reply_due [$];
    int     fail_count = 0;
    int     idle_pct = 0;
    int     stall_cycles = 0;

    shared_buffer_multi_queue_core #(
        .NUM_QUEUES  (NUM_QUEUES),
        .NUM_ENTRIES (NUM_ENTRIES),
        .DATA_WIDTH  (DATA_WIDTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req_type (req_type),
        .queue_id (queue_id),
        .data_in  (data_in),
        .done     (done),
        .status   (status),
        .data_out (data_out)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void reset_queue_model();
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            entry_val[i] = '0;
            next_ptr[i]  = 5'(i + 1);
        end
        next_ptr[NUM_ENTRIES-1] = PTR_NONE;
        for (int q = 0; q < NUM_QUEUES; q++)
        begin
            head_ptr[q] = PTR_NONE;
            tail_ptr[q] = '0;
        end
        free_ptr = '0;
    endfunction

    function automatic reply_t apply_queue_op(logic rt, logic [1:0] qid,
                                              logic signed [31:0] d);
        reply_t     r;
        logic [4:0] slot;
        r.st   = ST_OK;
        r.data = '0;
        if (rt == REQ_ENQ)
        begin
            slot = free_ptr;
            if (slot >= NUM_ENTRIES)
                r.st = ST_OVERFLOW;
            else
            begin
                free_ptr = next_ptr[slot[3:0]];
                if (head_ptr[qid] >= NUM_ENTRIES)
                    head_ptr[qid] = slot;
                else
                    next_ptr[tail_ptr[qid]] = slot;
                next_ptr[slot[3:0]]  = PTR_NONE;
                tail_ptr[qid]        = slot[3:0];
                entry_val[slot[3:0]] = d;
            end
        end
        else
        begin
            slot = head_ptr[qid];
            if (slot >= NUM_ENTRIES)
                r.st = ST_UNDERFLOW;
            else
            begin
                head_ptr[qid]       = next_ptr[slot[3:0]];
                next_ptr[slot[3:0]] = free_ptr;
                free_ptr            = slot;
                r.data              = entry_val[slot[3:0]];
            end
        end
        return r;
    endfunction

    // Called just after a rising edge; returns at the edge that takes the request.
    task automatic send_request(input logic rt, input logic [1:0] qid,
                                input logic signed [31:0] d);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start    <= 1'b1;
        req_type <= rt;
        queue_id <= qid;
        data_in  <= d;
        do
            @(posedge clk);
        while (busy);
        reply_due.push_back(apply_queue_op(rt, qid, d));
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (reply_due.size() != 0);
    endtask

    task automatic test_corner_values();
        idle_pct = 6;
        for (int q = 0; q < NUM_QUEUES; q++)
            send_request(REQ_DEQ, 2'(q), 32'sh5A5A5A5A);
        send_request(REQ_ENQ, 2'd0, 32'sh7FFFFFFF);
        send_request(REQ_ENQ, 2'd1, 32'sh80000000);
        send_request(REQ_ENQ, 2'd2, 32'sh00000000);
        send_request(REQ_ENQ, 2'd3, 32'shFFFFFFFF);
        send_request(REQ_ENQ, 2'd0, 32'shAAAAAAAA);
        send_request(REQ_DEQ, 2'd0, 32'sh0);
        send_request(REQ_DEQ, 2'd0, 32'sh0);
        send_request(REQ_DEQ, 2'd0, 32'sh0);
        for (int q = 1; q < NUM_QUEUES; q++)
            send_request(REQ_DEQ, 2'(q), 32'shFFFFFFFF);
    endtask

    // Fill every entry, overflow, then unwind in mixed order.
    task automatic test_full_store();
        idle_pct = 6;
        for (int i = 0; i < NUM_ENTRIES; i++)
            send_request(REQ_ENQ, 2'($urandom_range(3)), $urandom());
        send_request(REQ_ENQ, 2'd1, 32'sh55555555);
        wait_drained();
        send_request(REQ_ENQ, 2'd2, 32'sh12345678);
        for (int i = 0; i < NUM_ENTRIES + 4; i++)
            send_request(REQ_DEQ, 2'(i % NUM_QUEUES), $urandom());
    endtask

    task automatic test_random_traffic(input int pct, input int count);
        int                 enq_pct;
        int                 pick;
        logic signed [31:0] d;
        idle_pct = pct;
        enq_pct  = 50;
        for (int i = 0; i < count; i++)
        begin
            // drift the mix so the store swings between full and empty
            if (i % 32 == 0)
                enq_pct = 25 * $urandom_range(1, 3);
            if ($urandom_range(49) == 0)
                wait_drained();
            pick = $urandom_range(15);
            case (pick)
                0:       d = 32'sh7FFFFFFF;
                1:       d = 32'sh80000000;
                2:       d = 32'sh00000000;
                3:       d = 32'shFFFFFFFF;
                default: d = $urandom();
            endcase
            send_request(($urandom_range(99) < enq_pct) ? REQ_ENQ : REQ_DEQ,
                         2'($urandom_range(3)), d);
        end
    endtask

    always @(posedge clk)
    begin
        reply_t exp_r;
        if (rst_n && done)
        begin
            if (reply_due.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result: status %0d data_out %h", status, data_out);
            end
            else
            begin
                exp_r = reply_due.pop_front();
                if (status !== exp_r.st || data_out !== exp_r.data)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("mismatch: status exp %0d got %0d, data_out exp %h got %h",
                                 exp_r.st, status, exp_r.data, data_out);
                end
            end
        end
    end

    // watchdog on cycles where neither a request nor a result moves
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        reset_queue_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_values();
        test_full_store();
        test_random_traffic(6, 215);
        test_random_traffic(76, 215);
        test_random_traffic(0, 215);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && reply_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ files.f @@
rtl/sbmq_pkg.sv
rtl/sbmq_queue_table.sv
rtl/sbmq_entry_store.sv
rtl/shared_buffer_multi_queue_core.sv
test/tb_shared_buffer_multi_queue_core.sv
